@@ rtl/rclfr_pkg.sv @@
// Package for the link frame receiver: sizes, codes, config struct, CRC-8 step.
// No dependencies; imported by every other file of the block but rclfr_ram.
`timescale 1ns / 1ps
`default_nettype none
package rclfr_pkg;

    localparam int MAX_FRAME_BYTES = 64;
    localparam int FRAME_AW        = $clog2(MAX_FRAME_BYTES);
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CHANNEL_COUNT   = 16;
    localparam int CHAN_IDX_W      = $clog2(CHANNEL_COUNT);
    localparam int CHANNEL_BITS    = 11;
    localparam int ACC_W           = CHANNEL_BITS + 7;
    localparam int ACC_BITS_W      = $clog2(ACC_W + 1);

    localparam logic [7:0] CRC_POLY = 8'hD5;
    localparam logic [7:0] RC_LENGTH = 8'd24;
    // payload of an RC frame sits between the type byte and the CRC byte
    localparam logic [FRAME_AW-1:0] PAYLOAD_FIRST = FRAME_AW'(3);
    localparam logic [FRAME_AW-1:0] PAYLOAD_LAST  = FRAME_AW'(24);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RC_TYPE    = 2'd2;

    localparam logic [5:0]  RESET_MAX_LENGTH = 6'd60;
    localparam logic [15:0] RESET_TIMEOUT    = 16'd2048;
    localparam logic [7:0]  RESET_RC_TYPE    = 8'd22;

    typedef logic [1:0] t_status;
    localparam t_status STATUS_OK         = 2'd0;
    localparam t_status STATUS_BAD_LENGTH = 2'd1;
    localparam t_status STATUS_BAD_CRC    = 2'd2;
    localparam t_status STATUS_BAD_TYPE   = 2'd3;

    typedef struct packed {
        logic [5:0]  max_length;
        logic [15:0] timeout_us;
        logic [7:0]  rc_type;
    } t_cfg;

    // one table lookup of the MSB-first CRC-8, written as its eight shift steps
    function automatic logic [7:0] crc8_byte(input logic [7:0] value);
        logic [7:0] c;
        c = value;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/rclfr_if.sv @@
// Channel interfaces of the link frame receiver: byte input, result output, config writes.
// Depends on rclfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rclfr_in_if import rclfr_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic [31:0] time_us;
    modport source (output valid, output rx_byte, output time_us, input ready);
    modport sink   (input valid, input rx_byte, input time_us, output ready);
endinterface

interface rclfr_out_if import rclfr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    t_status                 status;
    logic [CHAN_IDX_W-1:0]   channel_index;
    logic [CHANNEL_BITS-1:0] channel_value;
    logic                    last;
    modport source (output valid, output status, output channel_index,
                    output channel_value, output last, input ready);
    modport sink   (input valid, input status, input channel_index,
                    input channel_value, input last, output ready);
endinterface

interface rclfr_cfg_if import rclfr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/rc_link_frame_receiver_unit.sv @@
// Top level of the link frame receiver: config registers, front, job queue, back, store.
// Depends on rclfr_pkg, rclfr_if, rclfr_ram, rclfr_front, rclfr_fifo, rclfr_back.
//
// Usage:
//   i_in  carries one received byte (rx_byte) with its microsecond timestamp (time_us)
//         per transfer. Bytes are assembled as address, length, type, payload, CRC.
//   o_out carries results: sixteen channel transfers (index 0..15, last on 15) for a
//         valid RC frame, or one error transfer (status 1..3, last set) otherwise.
//         Bytes that do not complete a frame give nothing.
//   i_cfg writes max_length (index 0), frame_timeout_us (1) and rc_frame_type (2);
//         always ready, to be used only while the block is idle.
// Operation:
//   i_in takes a new byte in any cycle in which it is ready. An error result passes from
//   the completing byte through the job queue into the output register. A good RC frame
//   is unpacked from the frame store one byte read at a time (a read state, then a wait
//   state), one channel per eleven bits held; i_in stalls from the completing byte until
//   the last payload byte has been read, since the single frame store is shared with new
//   bytes. The two-entry job queue lets error frames keep arriving while results back up.
// Reset: synchronous, active low; clears the byte count, the queue and the output
//   register, and restores the register defaults. The frame store is not cleared.
// Stall: when o_out.ready is low the result is held and the back part waits; once the
//   queue fills, i_in.ready drops.
`timescale 1ns / 1ps
`default_nettype none
module rc_link_frame_receiver_unit import rclfr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rclfr_in_if.sink      i_in,
    rclfr_out_if.source   o_out,
    rclfr_cfg_if.sink     i_cfg
);
    // configuration registers
    t_cfg r_cfg, n_cfg;

    // store write side (front) and read side (back)
    logic                wr_en;
    logic [FRAME_AW-1:0] wr_addr;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic [FRAME_AW-1:0] rd_addr;
    logic [7:0]          rd_data;

    // job queue handshake
    logic    push_valid, push_ready;
    t_status push_status;
    logic    pop_valid, pop_ready;
    t_status pop_status;

    logic release_store;
    logic store_lock;

    assign i_cfg.ready = 1'b1;

    // take a register write; an index beyond the list is dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MAX_LENGTH: n_cfg.max_length = i_cfg.data[5:0];
                REG_TIMEOUT:    n_cfg.timeout_us = i_cfg.data[15:0];
                REG_RC_TYPE:    n_cfg.rc_type    = i_cfg.data[7:0];
                default:        n_cfg            = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_length <= RESET_MAX_LENGTH;
            r_cfg.timeout_us <= RESET_TIMEOUT;
            r_cfg.rc_type    <= RESET_RC_TYPE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    rclfr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_rx_byte     (i_in.rx_byte),
        .i_time_us     (i_in.time_us),
        .i_cfg         (r_cfg),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_push_valid  (push_valid),
        .o_push_status (push_status),
        .i_push_ready  (push_ready),
        .i_release     (release_store),
        .o_lock        (store_lock)
    );

    rclfr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rclfr_fifo u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push_valid  (push_valid),
        .i_push_status (push_status),
        .o_push_ready  (push_ready),
        .o_pop_valid   (pop_valid),
        .o_pop_status  (pop_status),
        .i_pop_ready   (pop_ready)
    );

    rclfr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (pop_valid),
        .i_job_status    (pop_status),
        .o_job_ready     (pop_ready),
        .o_rd_en         (rd_en),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (rd_data),
        .o_release       (release_store),
        .o_valid         (o_out.valid),
        .i_ready         (o_out.ready),
        .o_status        (o_out.status),
        .o_channel_index (o_out.channel_index),
        .o_channel_value (o_out.channel_value),
        .o_last          (o_out.last)
    );

`ifndef SYNTH
    // a completed frame always finds room in the job queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_valid |-> push_ready)
        else $error("job pushed into a full queue");

    // the back part hands the store back only while it holds it
    a_release_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        release_store |-> store_lock)
        else $error("store released while not locked");

    // no byte is written into the store while a good frame is being unpacked
    a_no_write_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_lock |-> !wr_en)
        else $error("store written while locked");
`endif
endmodule
`default_nettype wire

@@ rtl/rclfr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rclfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

@@ rtl/rclfr_front.sv @@
// Front part: frame assembly, timeout restart, running CRC and frame classification.
// Depends on rclfr_pkg; writes the frame store and pushes one job per completed frame.
`timescale 1ns / 1ps
`default_nettype none
module rclfr_front import rclfr_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [7:0]          i_rx_byte,
    input  wire logic [31:0]         i_time_us,
    input  wire t_cfg                i_cfg,
    output logic                     o_wr_en,
    output logic [FRAME_AW-1:0]      o_wr_addr,
    output logic [7:0]               o_wr_data,
    output logic                     o_push_valid,
    output t_status                  o_push_status,
    input  wire logic                i_push_ready,
    input  wire logic                i_release,
    output logic                     o_lock
);
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]      r_start, n_start;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_crc, n_crc;
    logic             r_lock, n_lock;

    logic             accept;
    logic             restart;
    logic [31:0]      elapsed;
    logic [CNT_W-1:0] eff_cnt;
    logic [CNT_W-1:0] new_cnt;
    logic [8:0]       len_plus2;
    logic             complete;
    t_status          status;

    assign o_ready = !r_lock && i_push_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        elapsed   = i_time_us - r_start;
        restart   = (r_cnt == '0) || (elapsed > {16'd0, i_cfg.timeout_us})
                    || (r_cnt >= CNT_W'(MAX_FRAME_BYTES));
        eff_cnt   = restart ? '0 : r_cnt;
        new_cnt   = eff_cnt + CNT_W'(1);
        len_plus2 = {1'b0, r_len} + 9'd2;
        complete  = (new_cnt >= CNT_W'(3)) && (9'(new_cnt) == len_plus2);

        if ((r_len < 8'd2) || (r_len > {2'b00, i_cfg.max_length})) begin
            status = STATUS_BAD_LENGTH;
        end else if (i_rx_byte != r_crc) begin
            status = STATUS_BAD_CRC;
        end else if ((r_type != i_cfg.rc_type) || (r_len != RC_LENGTH)) begin
            status = STATUS_BAD_TYPE;
        end else begin
            status = STATUS_OK;
        end
    end

    always_comb begin
        n_cnt   = r_cnt;
        n_start = r_start;
        n_len   = r_len;
        n_type  = r_type;
        n_crc   = r_crc;
        n_lock  = r_lock && !i_release;
        if (accept) begin
            n_start = restart ? i_time_us : r_start;
            n_cnt   = new_cnt;
            if (eff_cnt == CNT_W'(1)) begin
                n_len = i_rx_byte;
            end
            if (eff_cnt == CNT_W'(2)) begin
                n_type = i_rx_byte;
                n_crc  = crc8_byte(i_rx_byte);
            end else begin
                n_crc  = crc8_byte(r_crc ^ i_rx_byte);
            end
            if (complete) begin
                n_cnt   = '0;
                n_start = '0;
                // hold the store for the back part until it has read the payload
                n_lock  = (status == STATUS_OK);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_start <= '0;
            r_lock  <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_start <= n_start;
            r_lock  <= n_lock;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len  <= n_len;
        r_type <= n_type;
        r_crc  <= n_crc;
    end

    assign o_wr_en       = accept;
    assign o_wr_addr     = eff_cnt[FRAME_AW-1:0];
    assign o_wr_data     = i_rx_byte;
    assign o_push_valid  = accept && complete;
    assign o_push_status = status;
    assign o_lock        = r_lock;
endmodule
`default_nettype wire

@@ rtl/rclfr_fifo.sv @@
// Two-entry job queue between the front and back parts of the frame receiver.
// Depends on rclfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rclfr_fifo import rclfr_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push_valid,
    input  wire t_status i_push_status,
    output logic         o_push_ready,
    output logic         o_pop_valid,
    output t_status      o_pop_status,
    input  wire logic    i_pop_ready
);
    t_status    r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       push, pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_status = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_status;
        end
    end
endmodule
`default_nettype wire

@@ rtl/rclfr_back.sv @@
// Back part: turns a job into results, unpacking 11-bit channels from the frame store.
// Depends on rclfr_pkg; reads the store through the RAM read port.
`timescale 1ns / 1ps
`default_nettype none
module rclfr_back import rclfr_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_job_valid,
    input  wire t_status                 i_job_status,
    output logic                         o_job_ready,
    output logic                         o_rd_en,
    output logic [FRAME_AW-1:0]          o_rd_addr,
    input  wire logic [7:0]              i_rd_data,
    output logic                         o_release,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output t_status                      o_status,
    output logic [CHAN_IDX_W-1:0]        o_channel_index,
    output logic [CHANNEL_BITS-1:0]      o_channel_value,
    output logic                         o_last
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0]              r_state, n_state;
    logic [ACC_W-1:0]        r_acc, n_acc;
    logic [ACC_BITS_W-1:0]   r_bits, n_bits;
    logic [FRAME_AW-1:0]     r_addr, n_addr;
    logic [CHAN_IDX_W-1:0]   r_chan, n_chan;
    logic                    r_out_valid, n_out_valid;
    t_status                 r_out_status, n_out_status;
    logic [CHAN_IDX_W-1:0]   r_out_index, n_out_index;
    logic [CHANNEL_BITS-1:0] r_out_value, n_out_value;
    logic                    r_out_last, n_out_last;
    logic                    out_free;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state      = r_state;
        n_acc        = r_acc;
        n_bits       = r_bits;
        n_addr       = r_addr;
        n_chan       = r_chan;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_index  = r_out_index;
        n_out_value  = r_out_value;
        n_out_last   = r_out_last;
        o_job_ready  = 1'b0;
        o_rd_en      = 1'b0;
        o_release    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    if (i_job_status != STATUS_OK) begin
                        if (out_free) begin
                            o_job_ready  = 1'b1;
                            n_out_valid  = 1'b1;
                            n_out_status = i_job_status;
                            n_out_index  = '0;
                            n_out_value  = '0;
                            n_out_last   = 1'b1;
                        end
                    end else begin
                        o_job_ready = 1'b1;
                        n_acc       = '0;
                        n_bits      = '0;
                        n_addr      = PAYLOAD_FIRST;
                        n_chan      = '0;
                        n_state     = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                if (r_bits >= ACC_BITS_W'(CHANNEL_BITS)) begin
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_status = STATUS_OK;
                        n_out_index  = r_chan;
                        n_out_value  = r_acc[CHANNEL_BITS-1:0];
                        n_out_last   = (r_chan == CHAN_IDX_W'(CHANNEL_COUNT - 1));
                        n_acc        = r_acc >> CHANNEL_BITS;
                        n_bits       = r_bits - ACC_BITS_W'(CHANNEL_BITS);
                        n_chan       = r_chan + CHAN_IDX_W'(1);
                        if (r_chan == CHAN_IDX_W'(CHANNEL_COUNT - 1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    o_rd_en = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_acc   = r_acc | (ACC_W'(i_rd_data) << r_bits);
                n_bits  = r_bits + ACC_BITS_W'(8);
                n_addr  = r_addr + FRAME_AW'(1);
                // last payload byte is in hand: the store may take new bytes
                o_release = (r_addr == PAYLOAD_LAST);
                n_state = S_LOAD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc        <= n_acc;
        r_bits       <= n_bits;
        r_addr       <= n_addr;
        r_chan       <= n_chan;
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
        r_out_value  <= n_out_value;
        r_out_last   <= n_out_last;
    end

    assign o_rd_addr       = r_addr;
    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_channel_index = r_out_index;
    assign o_channel_value = r_out_value;
    assign o_last          = r_out_last;
endmodule
`default_nettype wire

@@ verif/rc_link_frame_receiver_unit_tb.sv @@
// Self-checking testbench for rc_link_frame_receiver_unit: frames go in as timestamped bytes,
// results are checked against a built-in frame decoder across several register settings.
// Depends on rclfr_pkg, the rclfr_*_if interfaces and the RTL of the block.
`timescale 1ns / 1ps
module rc_link_frame_receiver_unit_tb;
    import rclfr_pkg::*;

    localparam int STALL_LIMIT   = 4000;  // cycles without any transfer before giving up
    localparam int LONG_HOLD     = 400;   // one long receiver hold-off
    localparam int SETTLE_CYCLES = 100;   // covers the longest unpack of a good frame
    localparam int MAX_REPORTS   = 10;
    localparam int MAX_SENT      = 66;    // longest byte run a single frame call emits

    typedef struct packed {
        logic [7:0]  value;
        logic [31:0] stamp;
    } t_rx_byte;

    typedef struct packed {
        t_status                 status;
        logic [CHAN_IDX_W-1:0]   channel_index;
        logic [CHANNEL_BITS-1:0] channel_value;
        logic                    last;
    } t_chan_result;

    typedef enum logic [1:0] {
        RX_OPEN,   // always ready
        RX_LIGHT,  // occasional stalls
        RX_HEAVY,  // mostly stalled
        RX_PULSE   // regular on/off pattern
    } t_rx_pattern;

    logic i_clk;
    logic i_rst_n;

    rclfr_in_if  in_if ();
    rclfr_out_if out_if ();
    rclfr_cfg_if cfg_if ();

    rc_link_frame_receiver_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // register copies, written only while the block is idle
    logic [5:0]  cfg_max_len;
    logic [15:0] cfg_tmo;
    logic [7:0]  cfg_rc_type;

    // decoder state: bytes of the frame being gathered and its start stamp
    logic [7:0]  frame_bytes [MAX_FRAME_BYTES];
    int          held_bytes;
    logic [31:0] frame_start;
    logic [7:0]  crc_lut [256];

    t_rx_byte     byte_backlog [$];
    t_chan_result expected_results [$];

    // stimulus bookkeeping
    logic [31:0] clock_us;
    bit          need_resync;
    bit          hold_armed;
    int          bytes_queued;
    int          frames_queued;

    // counters
    int bytes_accepted;
    int results_seen;
    int status_seen [4];
    int fail_count;
    int mismatch_count;

    // driver, receiver and watchdog working state
    int          send_burst;
    int          send_gap;
    t_rx_byte    next_byte;
    int          hold_left;
    bit          hold_done;
    int          pattern_left;
    t_rx_pattern rx_pattern;
    t_chan_result mon_exp;
    t_chan_result mon_got;
    int          idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Decoder: fold one accepted byte into the frame and queue the results
    // ------------------------------------------------------------------
    task automatic note_failure(input string what);
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] %s", $realtime, what);
        end
    endtask

    task automatic expect_error(input t_status code);
        t_chan_result r;
        r.status        = code;
        r.channel_index = '0;
        r.channel_value = '0;
        r.last          = 1'b1;
        expected_results.push_back(r);
    endtask

    task automatic decode_byte(input logic [7:0] rx, input logic [31:0] stamp);
        int           len;
        int           i;
        int           bitpos;
        int           at;
        logic [7:0]   crc;
        logic [23:0]  word;
        t_chan_result r;

        // first byte opens a frame; a late byte or a full store restarts it
        if (held_bytes == 0) begin
            frame_start = stamp;
        end else if ((stamp - frame_start) > {16'd0, cfg_tmo} ||
                     held_bytes >= MAX_FRAME_BYTES) begin
            held_bytes  = 0;
            frame_start = stamp;
        end
        if (held_bytes < MAX_FRAME_BYTES) begin
            frame_bytes[held_bytes] = rx;
        end
        held_bytes++;

        if (held_bytes >= 3 && held_bytes == int'(frame_bytes[1]) + 2) begin
            held_bytes  = 0;
            frame_start = '0;
            len         = int'(frame_bytes[1]);
            if (len < 2 || len > int'(cfg_max_len)) begin
                expect_error(STATUS_BAD_LENGTH);
            end else begin
                // CRC runs over type and payload, check byte follows them
                crc = 8'h00;
                for (i = 2; i <= len; i++) begin
                    crc = crc_lut[crc ^ frame_bytes[i]];
                end
                if (crc != frame_bytes[len + 1]) begin
                    expect_error(STATUS_BAD_CRC);
                end else if (frame_bytes[2] != cfg_rc_type || len != int'(RC_LENGTH)) begin
                    expect_error(STATUS_BAD_TYPE);
                end else begin
                    // sixteen 11-bit channels packed LSB first from the first payload byte
                    for (i = 0; i < CHANNEL_COUNT; i++) begin
                        bitpos = i * CHANNEL_BITS;
                        at     = 3 + bitpos / 8;
                        word   = {frame_bytes[at + 2], frame_bytes[at + 1], frame_bytes[at]};
                        r.status        = STATUS_OK;
                        r.channel_index = CHAN_IDX_W'(i);
                        r.channel_value = CHANNEL_BITS'(word >> (bitpos % 8));
                        r.last          = (i == CHANNEL_COUNT - 1);
                        expected_results.push_back(r);
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    // Queue one frame: address, length, type, payload, check byte. fill < 0 gives a random
    // payload. break_at >= 0 makes that byte arrive just after the timeout; stretch puts the
    // last byte exactly on the timeout, which must still be accepted.
    task automatic queue_frame(input int len, input logic [7:0] ftype, input int fill,
                               input bit bad_crc, input int break_at, input bit stretch);
        logic [7:0]  fb [MAX_SENT];
        logic [7:0]  crc;
        logic [31:0] t0;
        int          n;
        int          i;
        int          max_gap;

        n = (len + 2 > MAX_SENT) ? MAX_SENT : len + 2;
        fb[0] = 8'($urandom_range(0, 255));
        fb[1] = 8'(len);
        if (n > 2) begin
            fb[2] = ftype;
        end
        for (i = 3; i < n; i++) begin
            fb[i] = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
        end
        if (len >= 2 && len <= 62) begin
            crc = 8'h00;
            for (i = 2; i <= len; i++) begin
                crc = crc_lut[crc ^ fb[i]];
            end
            fb[len + 1] = bad_crc ? (crc ^ 8'($urandom_range(1, 255))) : crc;
        end

        // a long silence flushes whatever half frame an earlier sequence left behind
        if (need_resync) begin
            clock_us    = clock_us + 32'(cfg_tmo) + 32'd1 + 32'($urandom_range(0, 200));
            need_resync = 1'b0;
        end
        t0      = clock_us;
        max_gap = int'(cfg_tmo) / n;
        if (max_gap > 40) begin
            max_gap = 40;
        end
        for (i = 0; i < n; i++) begin
            if (i > 0) begin
                clock_us = clock_us + 32'($urandom_range(0, max_gap));
            end
            if (i == break_at) begin
                clock_us = t0 + 32'(cfg_tmo) + 32'd1 + 32'($urandom_range(0, 3));
            end
            if (stretch && i == n - 1) begin
                clock_us = t0 + 32'(cfg_tmo);
            end
            byte_backlog.push_back('{value: fb[i], stamp: clock_us});
        end
        if (break_at >= 0 || len == 0 || len > 62) begin
            need_resync = 1'b1;
        end
        bytes_queued += n;
        frames_queued++;
    endtask

    task automatic queue_random_frame();
        int         r;
        int         len;
        int         k;
        int         i;
        logic [7:0] t;

        r = $urandom_range(0, 99);
        if (r < 34) begin
            queue_frame(RC_LENGTH, cfg_rc_type, -1, 1'b0, -1, 1'b0);
        end else if (r < 46) begin
            // corrupted check byte
            len = $urandom_range(0, 1) ? int'(RC_LENGTH) : $urandom_range(2, cfg_max_len);
            t   = $urandom_range(0, 1) ? cfg_rc_type : 8'($urandom_range(0, 255));
            queue_frame(len, t, -1, 1'b1, -1, 1'b0);
        end else if (r < 56) begin
            // some other frame type
            len = $urandom_range(0, 1) ? int'(RC_LENGTH) : $urandom_range(2, cfg_max_len);
            t   = cfg_rc_type ^ 8'($urandom_range(1, 255));
            queue_frame(len, t, -1, 1'b0, -1, 1'b0);
        end else if (r < 63) begin
            // RC type with the wrong size
            len = $urandom_range(2, cfg_max_len);
            if (len == int'(RC_LENGTH)) begin
                len = (cfg_max_len > 6'd24) ? 25 : 23;
            end
            queue_frame(len, cfg_rc_type, -1, 1'b0, -1, 1'b0);
        end else if (r < 68) begin
            queue_frame(1, 8'($urandom_range(0, 255)), -1, 1'b0, -1, 1'b0);
        end else if (r < 76) begin
            // length above the limit but still fitting the store (one if the limit is 62 or more)
            len = (cfg_max_len < 6'd62) ? $urandom_range(int'(cfg_max_len) + 1, 62) : 1;
            queue_frame(len, 8'($urandom_range(0, 255)), -1, 1'b0, -1, 1'b0);
        end else if (r < 81) begin
            // length that can never fit: store fills and the next byte restarts
            queue_frame($urandom_range(63, 255), 8'($urandom_range(0, 255)), -1, 1'b0, -1,
                        1'b0);
        end else if (r < 89) begin
            queue_frame(RC_LENGTH, cfg_rc_type, -1, 1'b0, $urandom_range(1, 25), 1'b0);
        end else if (r < 94) begin
            // line noise after a jump to an arbitrary timestamp
            k        = $urandom_range(1, 8);
            clock_us = $urandom;
            for (i = 0; i < k; i++) begin
                clock_us = clock_us + 32'($urandom_range(0, 3));
                byte_backlog.push_back('{value: 8'($urandom_range(0, 255)), stamp: clock_us});
            end
            bytes_queued += k;
            need_resync = 1'b1;
        end else if (r < 97) begin
            queue_frame(0, 8'($urandom_range(0, 255)), -1, 1'b0, -1, 1'b0);
        end else begin
            queue_frame(RC_LENGTH, cfg_rc_type, -1, 1'b0, -1, 1'b1);
        end
    endtask

    task automatic queue_random_bytes(input int budget);
        int stop_at;
        stop_at = bytes_queued + budget;
        while (bytes_queued < stop_at) begin
            queue_random_frame();
        end
    endtask

    // hold until every byte is in and every result is out, then let the block settle
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (byte_backlog.size() != 0 || in_if.valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_MAX_LENGTH: cfg_max_len = val[5:0];
            REG_TIMEOUT:    cfg_tmo     = val[15:0];
            REG_RC_TYPE:    cfg_rc_type = val[7:0];
            default:        ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Byte sender: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_burst  = $urandom_range(1, 32);
            send_gap    = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                decode_byte(in_if.rx_byte, in_if.time_us);
                bytes_accepted++;
            end
            // advance only when the current byte is gone or nothing is on offer
            if (!in_if.valid || in_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_if.valid <= 1'b0;
                end else if (byte_backlog.size() != 0) begin
                    next_byte = byte_backlog.pop_front();
                    in_if.valid   <= 1'b1;
                    in_if.rx_byte <= next_byte.value;
                    in_if.time_us <= next_byte.stamp;
                    if (send_burst > 1) begin
                        send_burst--;
                    end else begin
                        send_burst = $urandom_range(1, 32);
                        send_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: stall pattern that changes every so often, plus one long
    // hold-off so the job queue fills and the input side backs up
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_left    = 0;
            hold_done    = 1'b0;
            pattern_left = 0;
            rx_pattern   = RX_OPEN;
        end else begin
            if (hold_armed && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    rx_pattern   = t_rx_pattern'($urandom_range(0, 3));
                    pattern_left = $urandom_range(20, 120);
                end
                pattern_left--;
                case (rx_pattern)
                    RX_OPEN:  out_if.ready <= 1'b1;
                    RX_LIGHT: out_if.ready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY: out_if.ready <= ($urandom_range(0, 2) == 0);
                    default:  out_if.ready <= ((pattern_left % 8) < 4);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each transfer with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            mon_got.status        = out_if.status;
            mon_got.channel_index = out_if.channel_index;
            mon_got.channel_value = out_if.channel_value;
            mon_got.last          = out_if.last;
            results_seen++;
            status_seen[mon_got.status]++;
            if (expected_results.size() == 0) begin
                note_failure($sformatf("unexpected result: status %0d ch %0d val %0d last %0d",
                                       mon_got.status, mon_got.channel_index,
                                       mon_got.channel_value, mon_got.last));
            end else begin
                mon_exp = expected_results.pop_front();
                if (mon_exp !== mon_got) begin
                    note_failure($sformatf(
                        "result %0d: expected status %0d ch %0d val %0d last %0d, got status %0d ch %0d val %0d last %0d",
                        results_seen, mon_exp.status, mon_exp.channel_index,
                        mon_exp.channel_value, mon_exp.last, mon_got.status,
                        mon_got.channel_index, mon_got.channel_value, mon_got.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any transfer on any channel counts as progress
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles, %0d results still expected",
                     idle_cycles, expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed frames, then random traffic under four settings
    // ------------------------------------------------------------------
    initial begin
        int i;
        int b;
        logic [7:0] c;

        // known levels on every input from time zero
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.rx_byte = '0;
        in_if.time_us = '0;
        out_if.ready  = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = '0;
        cfg_if.data   = '0;

        for (i = 0; i < 256; i++) begin
            c = 8'(i);
            for (b = 0; b < 8; b++) begin
                c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            end
            crc_lut[i] = c;
        end
        for (i = 0; i < MAX_FRAME_BYTES; i++) begin
            frame_bytes[i] = 8'h00;
        end
        held_bytes     = 0;
        frame_start    = '0;
        cfg_max_len    = RESET_MAX_LENGTH;
        cfg_tmo        = RESET_TIMEOUT;
        cfg_rc_type    = RESET_RC_TYPE;
        clock_us       = $urandom;
        need_resync    = 1'b0;
        hold_armed     = 1'b0;
        bytes_queued   = 0;
        frames_queued  = 0;
        bytes_accepted = 0;
        results_seen   = 0;
        fail_count     = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        for (i = 0; i < 4; i++) begin
            status_seen[i] = 0;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // hold the receiver off while the first good frames arrive, so the input backs up
        hold_armed = 1'b1;

        // directed frames under the reset settings
        clock_us = 32'hFFFF_FFF0;                                       // stamps wrap mid-frame
        queue_frame(RC_LENGTH, cfg_rc_type, 8'h00, 1'b0, -1, 1'b0);   // all channels zero
        queue_frame(RC_LENGTH, cfg_rc_type, 8'hFF, 1'b0, -1, 1'b0);   // all channels full scale
        queue_frame(RC_LENGTH, cfg_rc_type, -1, 1'b0, -1, 1'b1);      // last byte on the timeout
        queue_frame(RC_LENGTH, cfg_rc_type, -1, 1'b1, -1, 1'b0);      // corrupted check byte
        queue_frame(10, cfg_rc_type, -1, 1'b0, -1, 1'b0);             // RC type, wrong size
        queue_frame(2, 8'h00, -1, 1'b0, -1, 1'b0);                    // shortest legal length
        queue_frame(1, 8'h55, -1, 1'b0, -1, 1'b0);                    // length below two
        queue_frame(RC_LENGTH, cfg_rc_type, -1, 1'b0, 12, 1'b0);      // timeout mid-frame
        queue_frame(0, 8'h00, -1, 1'b0, -1, 1'b0);                    // length zero never ends
        queue_frame(255, 8'hFF, -1, 1'b0, -1, 1'b0);                  // overfills the store

        // drain completely before the random traffic starts
        wait_idle();

        queue_random_bytes(25);
        wait_idle();

        // widest settings
        write_reg(REG_MAX_LENGTH, 16'd62);
        write_reg(REG_TIMEOUT, 16'hFFFF);
        write_reg(REG_RC_TYPE, 16'h00FF);
        queue_random_bytes(15);
        wait_idle();

        // tightest settings: only length two is in range, bytes of a frame share one stamp
        write_reg(REG_MAX_LENGTH, 16'd2);
        write_reg(REG_TIMEOUT, 16'd0);
        write_reg(REG_RC_TYPE, 16'h0000);
        queue_random_bytes(10);
        wait_idle();

        // limit exactly at the RC length, random timeout and type; spare data bits set
        write_reg(REG_MAX_LENGTH, {10'($urandom_range(0, 1023)), 6'd24});
        write_reg(REG_TIMEOUT, 16'($urandom_range(30, 5000)));
        write_reg(REG_RC_TYPE, 16'($urandom_range(0, 65535)));
        queue_random_bytes(15);
        wait_idle();

        if (expected_results.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", expected_results.size()));
        end

        $display("Covered %0d bytes in %0d frames under four register settings.",
                 bytes_accepted, frames_queued);
        $display("Results: %0d channel, %0d bad length, %0d bad crc, %0d bad type; %0d failures.",
                 status_seen[STATUS_OK], status_seen[STATUS_BAD_LENGTH],
                 status_seen[STATUS_BAD_CRC], status_seen[STATUS_BAD_TYPE], fail_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
